// File: sv/rv64ie_pkg.sv
// shared types, constants and helpers for the rv64im instruction executor
package rv64ie_pkg;

  localparam int XLEN     = 64;
  localparam int NUM_REGS = 32;
  localparam int NUM_CSRS = 4;
  localparam int QDEPTH   = 2;

  localparam logic [63:0] RESET_PC    = 64'h0000_0000_8000_0000;
  localparam logic [63:0] ECALL_CAUSE = 64'd11;
  localparam logic [4:0]  REG_A0      = 5'd10;

  // item codes on the input channel
  localparam logic ITEM_EXEC      = 1'b0;
  localparam logic ITEM_LOAD_DATA = 1'b1;

  // major opcodes
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OPIMMW = 7'h1b;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OPW    = 7'h3b;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [5:0] F6_SRL  = 6'h00;
  localparam logic [5:0] F6_SRA  = 6'h10;

  localparam logic [31:0] INS_ECALL  = 32'h0000_0073;
  localparam logic [31:0] INS_EBREAK = 32'h0010_0073;
  localparam logic [31:0] INS_MRET   = 32'h3020_0073;

  // csr addresses and their storage slots
  localparam logic [11:0] CSR_ADDR_MTVEC   = 12'h305;
  localparam logic [11:0] CSR_ADDR_MEPC    = 12'h341;
  localparam logic [11:0] CSR_ADDR_MSTATUS = 12'h300;
  localparam logic [11:0] CSR_ADDR_MCAUSE  = 12'h342;
  localparam logic [1:0]  SLOT_MCAUSE  = 2'd0;
  localparam logic [1:0]  SLOT_MSTATUS = 2'd1;
  localparam logic [1:0]  SLOT_MEPC    = 2'd2;
  localparam logic [1:0]  SLOT_MTVEC   = 2'd3;

  typedef enum logic [2:0] {
    RK_RETIRED   = 3'd0,
    RK_LOAD_REQ  = 3'd1,
    RK_STORE_REQ = 3'd2,
    RK_HALT      = 3'd3,
    RK_ILLEGAL   = 3'd4,
    RK_BAD_DATA  = 3'd5
  } result_kind_t;

  typedef enum logic [4:0] {
    CL_LUI, CL_AUIPC, CL_JAL, CL_JALR, CL_BRANCH, CL_LOAD, CL_STORE,
    CL_OPIMM, CL_OPIMMW, CL_OP, CL_OPW, CL_MULDIV, CL_ECALL, CL_MRET,
    CL_EBREAK, CL_CSR, CL_ILLEGAL, CL_LOAD_DATA
  } cls_t;

  typedef enum logic [2:0] {
    MD_MUL, MD_MULH, MD_MULHSU, MD_MULHU, MD_DIV, MD_DIVU, MD_REM, MD_REMU
  } md_op_t;

  // one classified transaction as it travels through the queue
  typedef struct packed {
    cls_t        cls;
    logic [2:0]  f3;
    logic        alt;
    logic        word;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [1:0]  csr_slot;
    logic [63:0] imm;
    logic [63:0] load_data;
  } dec_t;

  typedef struct packed {
    logic        start;
    md_op_t      op;
    logic        word;
    logic [63:0] a;
    logic [63:0] b;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } md_rsp_t;

  function automatic logic [63:0] sext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

// File: sv/rv64ie_front.sv
// front end: takes input transactions and classifies instructions
module rv64ie_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               opcode,
  input  logic [31:0]        instruction_word,
  input  logic [63:0]        load_data,
  input  logic               q_full,
  output logic               q_push,
  output rv64ie_pkg::dec_t   q_data
);
  import rv64ie_pkg::*;

  logic [31:0] ins;
  logic [6:0]  opc;
  logic [6:0]  f7;
  logic [2:0]  f3;
  logic [63:0] imm_i, imm_s, imm_b, imm_j, imm_u;
  logic        csr_ok;
  logic [1:0]  slot;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  assign ins = instruction_word;
  assign opc = ins[6:0];
  assign f3  = ins[14:12];
  assign f7  = ins[31:25];

  // immediate formats
  assign imm_i = {{52{ins[31]}}, ins[31:20]};
  assign imm_s = {{52{ins[31]}}, ins[31:25], ins[11:7]};
  assign imm_b = {{51{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign imm_j = {{43{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
  assign imm_u = {{32{ins[31]}}, ins[31:12], 12'b0};

  // csr address lookup
  always_comb begin
    csr_ok = 1'b1;
    slot   = SLOT_MCAUSE;
    case (ins[31:20])
      CSR_ADDR_MTVEC:   slot = SLOT_MTVEC;
      CSR_ADDR_MEPC:    slot = SLOT_MEPC;
      CSR_ADDR_MSTATUS: slot = SLOT_MSTATUS;
      CSR_ADDR_MCAUSE:  slot = SLOT_MCAUSE;
      default:          csr_ok = 1'b0;
    endcase
  end

  // classification
  always_comb begin
    q_data           = '0;
    q_data.f3        = f3;
    q_data.rd        = ins[11:7];
    q_data.rs1       = ins[19:15];
    q_data.rs2       = ins[24:20];
    q_data.csr_slot  = slot;
    q_data.imm       = imm_i;
    q_data.load_data = load_data;
    q_data.cls       = CL_ILLEGAL;
    if (opcode == ITEM_LOAD_DATA) begin
      q_data.cls = CL_LOAD_DATA;
    end else begin
      case (opc)
        OPC_LUI: begin
          q_data.cls = CL_LUI;
          q_data.imm = imm_u;
        end
        OPC_AUIPC: begin
          q_data.cls = CL_AUIPC;
          q_data.imm = imm_u;
        end
        OPC_JAL: begin
          q_data.cls = CL_JAL;
          q_data.imm = imm_j;
        end
        OPC_JALR: begin
          if (f3 == 3'd0) q_data.cls = CL_JALR;
        end
        OPC_BRANCH: begin
          q_data.imm = imm_b;
          if (f3 != 3'd2 && f3 != 3'd3) q_data.cls = CL_BRANCH;
        end
        OPC_LOAD: begin
          if (f3 != 3'd7) q_data.cls = CL_LOAD;
        end
        OPC_STORE: begin
          q_data.imm = imm_s;
          if (!f3[2]) q_data.cls = CL_STORE;
        end
        OPC_OPIMM: begin
          q_data.alt = (f3 == 3'd5) && ins[30];
          if (f3 == 3'd1) begin
            if (ins[31:26] == F6_SRL) q_data.cls = CL_OPIMM;
          end else if (f3 == 3'd5) begin
            if (ins[31:26] == F6_SRL || ins[31:26] == F6_SRA) q_data.cls = CL_OPIMM;
          end else begin
            q_data.cls = CL_OPIMM;
          end
        end
        OPC_OPIMMW: begin
          q_data.alt  = (f3 == 3'd5) && ins[30];
          q_data.word = 1'b1;
          if (f3 == 3'd0 || (f3 == 3'd1 && f7 == F7_BASE) ||
              (f3 == 3'd5 && (f7 == F7_BASE || f7 == F7_ALT))) begin
            q_data.cls = CL_OPIMMW;
          end
        end
        OPC_OP: begin
          q_data.alt = ins[30];
          if (f7 == F7_BASE || (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) begin
            q_data.cls = CL_OP;
          end else if (f7 == F7_MULDIV) begin
            q_data.cls = CL_MULDIV;
          end
        end
        OPC_OPW: begin
          q_data.alt  = ins[30];
          q_data.word = 1'b1;
          if ((f7 == F7_BASE && (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd5)) ||
              (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) begin
            q_data.cls = CL_OPW;
          end else if (f7 == F7_MULDIV && (f3 == 3'd0 || f3[2])) begin
            q_data.cls = CL_MULDIV;
          end
        end
        OPC_SYSTEM: begin
          if (f3 == 3'd0) begin
            if (ins == INS_EBREAK) begin
              q_data.cls = CL_EBREAK;
              q_data.rs2 = REG_A0;
            end else if (ins == INS_ECALL) begin
              q_data.cls = CL_ECALL;
            end else if (ins == INS_MRET) begin
              q_data.cls = CL_MRET;
            end
          end else if (f3 != 3'd4 && csr_ok) begin
            q_data.cls = CL_CSR;
          end
        end
        default: q_data.cls = CL_ILLEGAL;
      endcase
    end
  end

endmodule

// File: sv/rv64ie_queue.sv
// small fifo of classified transactions between front and back
module rv64ie_queue #(
  parameter int DEPTH = rv64ie_pkg::QDEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rv64ie_pkg::dec_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output rv64ie_pkg::dec_t head
);
  import rv64ie_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dec_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

// File: sv/rv64ie_muldiv.sv
// multi-cycle multiplier (32x32 partial products) and radix-2 divider
module rv64ie_muldiv (
  input  logic                clk,
  input  logic                rst,
  input  rv64ie_pkg::md_req_t req,
  output rv64ie_pkg::md_rsp_t rsp
);
  import rv64ie_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_MULFIX, S_DIV, S_DIVFIX} md_state_t;

  md_state_t    state;
  md_op_t       op;
  logic [63:0]  xa, xb;
  logic         sa, sb;
  logic [2:0]   step;
  logic [1:0]   pstep;
  logic [63:0]  prod;
  logic [127:0] acc;
  logic [63:0]  quo, rem, dvs, ea_keep;
  logic         qneg, rneg, bzero;
  logic [5:0]   cnt;

  logic         div_signed;
  logic [63:0]  ea, eb, ua, ub;
  logic [31:0]  pa, pb;
  logic [127:0] prod_sh;
  logic [64:0]  rs, rdiff;
  logic [63:0]  hi;

  // division operand preparation
  assign div_signed = !req.op[0];
  assign ea = req.word ? (div_signed ? sext32(req.a[31:0]) : {32'b0, req.a[31:0]}) : req.a;
  assign eb = req.word ? (div_signed ? sext32(req.b[31:0]) : {32'b0, req.b[31:0]}) : req.b;
  assign ua = (div_signed && ea[63]) ? (64'd0 - ea) : ea;
  assign ub = (div_signed && eb[63]) ? (64'd0 - eb) : eb;

  // partial product selection
  assign pa = step[1] ? xa[63:32] : xa[31:0];
  assign pb = step[0] ? xb[63:32] : xb[31:0];

  always_comb begin
    case (pstep)
      2'd0:    prod_sh = {64'b0, prod};
      2'd3:    prod_sh = {prod, 64'b0};
      default: prod_sh = {32'b0, prod, 32'b0};
    endcase
  end

  // restoring division step
  assign rs    = {rem, quo[63]};
  assign rdiff = rs - {1'b0, dvs};
  assign hi    = acc[127:64];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      // done pulses for one cycle after either fix-up state
      rsp.done <= (state == S_MULFIX) || (state == S_DIVFIX);
      case (state)
        S_IDLE: begin
          if (req.start) begin
            op      <= req.op;
            xa      <= req.a;
            xb      <= req.b;
            sa      <= req.a[63];
            sb      <= req.b[63];
            acc     <= '0;
            step    <= '0;
            quo     <= ua;
            rem     <= '0;
            dvs     <= ub;
            cnt     <= '0;
            ea_keep <= ea;
            bzero   <= (eb == 64'd0);
            qneg    <= div_signed && (ea[63] ^ eb[63]);
            rneg    <= div_signed && ea[63];
            state   <= req.op[2] ? S_DIV : S_MUL;
          end
        end
        S_MUL: begin
          // one partial product per cycle, registered in prod and then added into acc
          if (step != 3'd4) prod <= pa * pb;
          if (step != 3'd0) acc <= acc + prod_sh;
          pstep <= step[1:0];
          step  <= step + 3'd1;
          if (step == 3'd4) state <= S_MULFIX;
        end
        S_MULFIX: begin
          case (op)
            MD_MULH:   rsp.result <= hi - (sa ? xb : 64'd0) - (sb ? xa : 64'd0);
            MD_MULHSU: rsp.result <= hi - (sa ? xb : 64'd0);
            MD_MULHU:  rsp.result <= hi;
            default:   rsp.result <= acc[63:0];
          endcase
          state <= S_IDLE;
        end
        S_DIV: begin
          if (!rdiff[64]) begin
            rem <= rdiff[63:0];
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rs[63:0];
            quo <= {quo[62:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) state <= S_DIVFIX;
        end
        S_DIVFIX: begin
          if (op[1]) begin
            rsp.result <= bzero ? ea_keep : (rneg ? (64'd0 - rem) : rem);
          end else begin
            rsp.result <= bzero ? '1 : (qneg ? (64'd0 - quo) : quo);
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/rv64ie_back.sv
// back end: register file, csrs, pc, execution and the result register
module rv64ie_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [63:0]         cfg_data,
  input  logic                q_valid,
  input  rv64ie_pkg::dec_t    q_head,
  output logic                q_pop,
  output rv64ie_pkg::md_req_t md_req,
  input  rv64ie_pkg::md_rsp_t md_rsp,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          result_kind,
  output logic [63:0]         next_pc,
  output logic                reg_write_enable,
  output logic [4:0]          reg_index,
  output logic [63:0]         reg_value,
  output logic [63:0]         mem_address,
  output logic [3:0]          mem_size,
  output logic [63:0]         store_data,
  output logic [63:0]         halt_value
);
  import rv64ie_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_EXEC, B_WAIT, B_COMMIT} b_state_t;

  typedef struct packed {
    result_kind_t kind;
    logic [63:0]  npc;
    logic         wr;
    logic [4:0]   rd;
    logic [63:0]  val;
    logic [63:0]  addr;
    logic [3:0]   size;
    logic [63:0]  sdata;
    logic [63:0]  halt;
    logic         csr_we;
    logic [1:0]   csr_slot;
    logic [63:0]  csr_wdata;
    logic         ecall;
    logic         ld_set;
    logic         ld_signed;
  } res_t;

  b_state_t    state;
  dec_t        cur;
  res_t        r, res_q;
  logic [63:0] pc;
  logic [63:0] csr_q [NUM_CSRS];
  logic        ld_pending;
  logic [4:0]  ld_dest;
  logic [3:0]  ld_bytes;
  logic        ld_signed;
  logic [63:0] rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld;
  logic [63:0] rd_a, rd_b;
  logic        va, vb;

  logic        commit;
  logic [63:0] a, b, op2, sum, agen, alu, aluw, ld_ext, csr_old, csr_src, pc4;
  logic [5:0]  shamt;
  logic [31:0] sra_w;
  logic [63:0] sra_x;
  logic        taken;

  assign q_pop  = (state == B_IDLE) && q_valid;
  assign commit = (state == B_COMMIT) && (!out_valid || out_ready);

  // register file read data, zero until first written
  assign a   = va ? rd_a : 64'd0;
  assign b   = vb ? rd_b : 64'd0;
  assign pc4 = pc + 64'd4;

  // integer alu
  assign op2   = (cur.cls == CL_OP || cur.cls == CL_OPW) ? b : cur.imm;
  assign shamt = (cur.cls == CL_OP || cur.cls == CL_OPW) ? b[5:0] : cur.imm[5:0];
  assign sum   = (cur.alt && cur.f3 == 3'd0) ? (a - op2) : (a + op2);
  assign agen  = a + cur.imm;
  assign sra_w = $signed(a[31:0]) >>> shamt[4:0];
  assign sra_x = $signed(a) >>> shamt;

  always_comb begin
    case (cur.f3)
      3'd0:    alu = sum;
      3'd1:    alu = a << shamt;
      3'd2:    alu = {63'b0, $signed(a) < $signed(op2)};
      3'd3:    alu = {63'b0, a < op2};
      3'd4:    alu = a ^ op2;
      3'd5:    alu = cur.alt ? sra_x : (a >> shamt);
      3'd6:    alu = a | op2;
      default: alu = a & op2;
    endcase
  end

  always_comb begin
    case (cur.f3)
      3'd0:    aluw = sext32(sum[31:0]);
      3'd1:    aluw = sext32(a[31:0] << shamt[4:0]);
      3'd5:    aluw = cur.alt ? sext32(sra_w) : sext32(a[31:0] >> shamt[4:0]);
      default: aluw = '0;
    endcase
  end

  // branch condition
  always_comb begin
    case (cur.f3)
      3'd0:    taken = (a == b);
      3'd1:    taken = (a != b);
      3'd4:    taken = $signed(a) < $signed(b);
      3'd5:    taken = $signed(a) >= $signed(b);
      3'd6:    taken = a < b;
      3'd7:    taken = a >= b;
      default: taken = 1'b0;
    endcase
  end

  // returning load data, masked and extended
  always_comb begin
    case (ld_bytes)
      4'd1:    ld_ext = ld_signed ? {{56{cur.load_data[7]}}, cur.load_data[7:0]}
                                  : {56'b0, cur.load_data[7:0]};
      4'd2:    ld_ext = ld_signed ? {{48{cur.load_data[15]}}, cur.load_data[15:0]}
                                  : {48'b0, cur.load_data[15:0]};
      4'd4:    ld_ext = ld_signed ? sext32(cur.load_data[31:0])
                                  : {32'b0, cur.load_data[31:0]};
      default: ld_ext = cur.load_data;
    endcase
  end

  assign csr_old = csr_q[cur.csr_slot];
  assign csr_src = cur.f3[2] ? {59'b0, cur.rs1} : a;

  // execution of one transaction
  always_comb begin
    r          = '0;
    r.kind     = RK_RETIRED;
    r.npc      = pc4;
    r.rd       = cur.rd;
    r.csr_slot = cur.csr_slot;
    case (cur.cls)
      CL_LUI: begin
        r.wr  = 1'b1;
        r.val = cur.imm;
      end
      CL_AUIPC: begin
        r.wr  = 1'b1;
        r.val = pc + cur.imm;
      end
      CL_JAL: begin
        r.wr  = 1'b1;
        r.val = pc4;
        r.npc = pc + cur.imm;
      end
      CL_JALR: begin
        r.wr  = 1'b1;
        r.val = pc4;
        r.npc = {agen[63:1], 1'b0};
      end
      CL_BRANCH: begin
        if (taken) r.npc = pc + cur.imm;
      end
      CL_LOAD: begin
        r.kind      = RK_LOAD_REQ;
        r.addr      = agen;
        r.size      = 4'd1 << cur.f3[1:0];
        r.ld_set    = 1'b1;
        r.ld_signed = !cur.f3[2];
      end
      CL_STORE: begin
        r.kind = RK_STORE_REQ;
        r.addr = agen;
        r.size = 4'd1 << cur.f3[1:0];
        case (cur.f3[1:0])
          2'd0:    r.sdata = {56'b0, b[7:0]};
          2'd1:    r.sdata = {48'b0, b[15:0]};
          2'd2:    r.sdata = {32'b0, b[31:0]};
          default: r.sdata = b;
        endcase
      end
      CL_OPIMM, CL_OP: begin
        r.wr  = 1'b1;
        r.val = alu;
      end
      CL_OPIMMW, CL_OPW: begin
        r.wr  = 1'b1;
        r.val = aluw;
      end
      CL_MULDIV: begin
        r.wr = 1'b1;
      end
      CL_ECALL: begin
        r.ecall = 1'b1;
        r.npc   = csr_q[SLOT_MTVEC];
      end
      CL_MRET: begin
        r.npc = csr_q[SLOT_MEPC];
      end
      CL_EBREAK: begin
        r.kind = RK_HALT;
        r.npc  = pc;
        r.halt = b;
      end
      CL_CSR: begin
        r.wr     = 1'b1;
        r.val    = csr_old;
        r.csr_we = (cur.f3[1:0] == 2'b01) || (cur.rs1 != 5'd0);
        case (cur.f3[1:0])
          2'b01:   r.csr_wdata = csr_src;
          2'b10:   r.csr_wdata = csr_old | csr_src;
          default: r.csr_wdata = csr_old & ~csr_src;
        endcase
      end
      CL_LOAD_DATA: begin
        r.npc = pc;
        if (ld_pending) begin
          r.wr  = 1'b1;
          r.rd  = ld_dest;
          r.val = ld_ext;
        end else begin
          r.kind = RK_BAD_DATA;
        end
      end
      default: begin
        r.kind = RK_ILLEGAL;
        r.npc  = pc;
      end
    endcase
    if (!r.wr || r.rd == 5'd0) begin
      r.wr  = 1'b0;
      r.rd  = 5'd0;
      r.val = 64'd0;
    end
  end

  // multiply and divide requests
  always_comb begin
    md_req.start = (state == B_EXEC) && (cur.cls == CL_MULDIV);
    md_req.op    = md_op_t'(cur.f3);
    md_req.word  = cur.word;
    md_req.a     = a;
    md_req.b     = b;
  end

  // register file storage and reads
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_a <= rf_mem[q_head.rs1];
      rd_b <= rf_mem[q_head.rs2];
    end
    if (commit && res_q.wr) rf_mem[res_q.rd] <= res_q.val;
  end

  // sequencer, architectural state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      pc         <= RESET_PC;
      ld_pending <= 1'b0;
      ld_dest    <= '0;
      ld_bytes   <= '0;
      ld_signed  <= 1'b0;
      rf_vld     <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < NUM_CSRS; i++) csr_q[i] <= '0;
    end else begin
      if (out_valid && out_ready && !commit) out_valid <= 1'b0;
      if (cfg_we) pc <= cfg_data;
      case (state)
        B_IDLE: begin
          if (q_pop) begin
            cur   <= q_head;
            va    <= rf_vld[q_head.rs1];
            vb    <= rf_vld[q_head.rs2];
            state <= B_EXEC;
          end
        end
        B_EXEC: begin
          res_q <= r;
          state <= (cur.cls == CL_MULDIV) ? B_WAIT : B_COMMIT;
        end
        B_WAIT: begin
          if (md_rsp.done) begin
            if (res_q.wr) res_q.val <= cur.word ? sext32(md_rsp.result[31:0]) : md_rsp.result;
            state <= B_COMMIT;
          end
        end
        B_COMMIT: begin
          if (commit) begin
            out_valid        <= 1'b1;
            result_kind      <= res_q.kind;
            next_pc          <= res_q.npc;
            reg_write_enable <= res_q.wr;
            reg_index        <= res_q.rd;
            reg_value        <= res_q.val;
            mem_address      <= res_q.addr;
            mem_size         <= res_q.size;
            store_data       <= res_q.sdata;
            halt_value       <= res_q.halt;
            pc               <= res_q.npc;
            ld_pending       <= res_q.ld_set;
            if (res_q.ld_set) begin
              ld_dest   <= cur.rd;
              ld_bytes  <= res_q.size;
              ld_signed <= res_q.ld_signed;
            end
            if (res_q.wr) rf_vld[res_q.rd] <= 1'b1;
            if (res_q.csr_we) csr_q[res_q.csr_slot] <= res_q.csr_wdata;
            if (res_q.ecall) begin
              csr_q[SLOT_MEPC]   <= pc;
              csr_q[SLOT_MCAUSE] <= ECALL_CAUSE;
            end
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_no_x0_write: assert property (@(posedge clk) disable iff (rst)
    (state == B_COMMIT && res_q.wr) |-> (res_q.rd != 5'd0))
    else $error("commit writes x0");

  a_md_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    md_rsp.done |-> (state == B_WAIT))
    else $error("multiply/divide result outside wait");

  a_illegal_no_effect: assert property (@(posedge clk) disable iff (rst)
    (state == B_COMMIT && res_q.kind == RK_ILLEGAL) |->
      (!res_q.wr && !res_q.ld_set && !res_q.csr_we && !res_q.ecall))
    else $error("illegal instruction changes state");

  a_reset_pc: assert property (@(posedge clk)
    $fell(rst) |-> (pc == RESET_PC))
    else $error("pc not at reset value after reset");
`endif

endmodule

// File: sv/rv64im_instruction_executor_core.sv
// top level of the rv64im instruction executor
//
//  channel   handshake             payload
//  in        in_valid/in_ready     opcode, instruction_word, load_data
//  out       out_valid/out_ready   result_kind .. halt_value
//  cfg       cfg_valid/cfg_ready   cfg_data (pc)
//
// most transactions pass through the back end in read, execute and commit steps;
// multiplies, divides and remainders also wait on the shared multiply/divide unit,
// and divides and remainders there use its one-bit-per-cycle divider.
// the front queue keeps taking transactions while the back end works, until it is full.
// rst is synchronous: pc returns to 0x80000000, registers and csrs to zero.
// out holds its result until taken; the back end stalls at commit meanwhile.
module rv64im_instruction_executor_core #(
  parameter int QUEUE_DEPTH = rv64ie_pkg::QDEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [31:0] instruction_word,
  input  logic [63:0] load_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  result_kind,
  output logic [63:0] next_pc,
  output logic        reg_write_enable,
  output logic [4:0]  reg_index,
  output logic [63:0] reg_value,
  output logic [63:0] mem_address,
  output logic [3:0]  mem_size,
  output logic [63:0] store_data,
  output logic [63:0] halt_value
);
  import rv64ie_pkg::*;

  logic    q_full, q_push, q_pop, q_valid;
  dec_t    q_in, q_head;
  md_req_t md_req;
  md_rsp_t md_rsp;

  assign cfg_ready = 1'b1;

  rv64ie_front u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .opcode           (opcode),
    .instruction_word (instruction_word),
    .load_data        (load_data),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_in)
  );

  rv64ie_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  rv64ie_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  rv64ie_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .md_req           (md_req),
    .md_rsp           (md_rsp),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .result_kind      (result_kind),
    .next_pc          (next_pc),
    .reg_write_enable (reg_write_enable),
    .reg_index        (reg_index),
    .reg_value        (reg_value),
    .mem_address      (mem_address),
    .mem_size         (mem_size),
    .store_data       (store_data),
    .halt_value       (halt_value)
  );

endmodule
